// ----- design/tsv_pkg.sv -----
// Shared types, constants and character codes of the text stream visualiser.
`default_nettype none

package tsv_pkg;

    localparam int NUMBER_WIDTH_DEF = 6;
    localparam int COUNT_DIGITS     = 6;
    localparam int DIG_IDX_W        = $clog2(COUNT_DIGITS);
    localparam int DIG_CNT_W        = $clog2(COUNT_DIGITS + 1);
    localparam int BODY_MAX         = 4;
    localparam int BODY_IDX_W       = $clog2(BODY_MAX);
    localparam int QUEUE_DEPTH      = 2;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUMBER_MODE      = 3'd0,
        REG_SQUEEZE_BLANK    = 3'd1,
        REG_SHOW_ENDS        = 3'd2,
        REG_SHOW_TABS        = 3'd3,
        REG_SHOW_NONPRINTING = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0] number_mode;
        logic       squeeze_blank;
        logic       show_ends;
        logic       show_tabs;
        logic       show_nonprinting;
    } cfg_t;

    typedef logic [COUNT_DIGITS-1:0][3:0] bcd_t;

    // One classified input word: optional line number and up to four body bytes.
    typedef struct packed {
        logic                          numbered;
        bcd_t                          digits;
        logic [DIG_CNT_W-1:0]          ndig;
        logic [BODY_IDX_W-1:0]         body_last;
        logic [BODY_MAX-1:0][7:0]      body;
    } job_t;

    typedef enum logic [1:0] {
        PH_PAD,
        PH_DIGIT,
        PH_TAB,
        PH_BODY
    } phase_t;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [3:0] CH_DIGIT_HI = 4'h3;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DEL    = 8'h7F;

endpackage

`default_nettype wire

// ----- design/tsv_byte_if.sv -----
// Input channel carrying one raw byte of the text stream per word.
`default_nettype none

interface tsv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ----- design/tsv_render_if.sv -----
// Output channel carrying one rendered byte and its end-of-run mark per word.
`default_nettype none

interface tsv_render_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- design/tsv_cfg_if.sv -----
// Configuration write channel: register index and write data.
`default_nettype none

interface tsv_cfg_if;
    import tsv_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/tsv_front.sv -----
// Front end: accepts input bytes, tracks line state and classifies each byte into a job.
`default_nettype none

module tsv_front (
    input  logic           clk,
    input  logic           rst_n,
    tsv_byte_if.sink       text,
    input  tsv_pkg::cfg_t  cfg,
    input  logic           full,
    output logic           push,
    output tsv_pkg::job_t  push_job
);
    import tsv_pkg::*;

    logic       after_nl_reg, after_nl_next;
    logic       blank_reg, blank_next;
    bcd_t       line_reg, line_next;

    logic       accept;
    logic       is_nl;
    logic       is_tab;
    logic       drop;
    logic       numbered;
    logic       all_nines;
    logic       carry;
    bcd_t       line_inc;
    logic [7:0] lo;
    logic [7:0] lo0;
    logic [7:0] lo1;
    logic       lo_two;
    logic [DIG_CNT_W-1:0] ndig;

    assign text.ready = !full;
    assign accept     = text.valid && !full;
    assign is_nl      = (text.in_byte == CH_NL);
    assign is_tab     = (text.in_byte == CH_TAB);

    // A repeated empty line under squeeze is swallowed whole and leaves the state alone.
    assign drop     = after_nl_reg && cfg.squeeze_blank && is_nl && blank_reg;
    assign numbered = after_nl_reg && !drop &&
                      (cfg.number_mode[1] ? !is_nl : cfg.number_mode[0]);
    assign push     = accept && !drop;

    always_comb
    begin
        all_nines = 1'b1;
        carry     = 1'b1;
        line_inc  = line_reg;
        ndig      = DIG_CNT_W'(1);
        for (int i = 0; i < COUNT_DIGITS; i++)
        begin
            if (line_reg[i] != 4'd9)
            begin
                all_nines = 1'b0;
            end
            if (line_reg[i] != 4'd0)
            begin
                ndig = DIG_CNT_W'(i + 1);
            end
            if (carry)
            begin
                if (line_reg[i] == 4'd9)
                begin
                    line_inc[i] = 4'd0;
                end
                else
                begin
                    line_inc[i] = line_reg[i] + 4'd1;
                    carry       = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        after_nl_next = after_nl_reg;
        blank_next    = blank_reg;
        line_next     = line_reg;
        if (accept && !drop)
        begin
            after_nl_next = is_nl;
            if (after_nl_reg)
            begin
                blank_next = cfg.squeeze_blank && is_nl;
            end
            if (numbered && !all_nines)
            begin
                line_next = line_inc;
            end
        end
    end

    // Caret form of the low seven bits.
    always_comb
    begin
        lo     = {1'b0, text.in_byte[6:0]};
        lo0    = lo;
        lo1    = '0;
        lo_two = 1'b0;
        if (lo == CH_DEL)
        begin
            lo0    = CH_CARET;
            lo1    = CH_QMARK;
            lo_two = 1'b1;
        end
        else if (lo < 8'd32)
        begin
            lo0    = CH_CARET;
            lo1    = lo + 8'd64;
            lo_two = 1'b1;
        end
    end

    always_comb
    begin
        push_job           = '0;
        push_job.numbered  = numbered;
        push_job.digits    = line_reg;
        push_job.ndig      = ndig;
        if (is_nl)
        begin
            if (cfg.show_ends)
            begin
                push_job.body[0]   = CH_DOLLAR;
                push_job.body[1]   = CH_NL;
                push_job.body_last = BODY_IDX_W'(1);
            end
            else
            begin
                push_job.body[0]   = CH_NL;
            end
        end
        else if (is_tab)
        begin
            if (cfg.show_tabs)
            begin
                push_job.body[0]   = CH_CARET;
                push_job.body[1]   = CH_I;
                push_job.body_last = BODY_IDX_W'(1);
            end
            else
            begin
                push_job.body[0]   = CH_TAB;
            end
        end
        else if (cfg.show_nonprinting)
        begin
            if (text.in_byte[7])
            begin
                push_job.body[0]   = CH_M;
                push_job.body[1]   = CH_DASH;
                push_job.body[2]   = lo0;
                push_job.body[3]   = lo1;
                push_job.body_last = lo_two ? BODY_IDX_W'(3) : BODY_IDX_W'(2);
            end
            else
            begin
                push_job.body[0]   = lo0;
                push_job.body[1]   = lo1;
                push_job.body_last = lo_two ? BODY_IDX_W'(1) : BODY_IDX_W'(0);
            end
        end
        else
        begin
            push_job.body[0] = text.in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            after_nl_reg <= 1'b1;
            blank_reg    <= 1'b0;
            line_reg     <= bcd_t'(1);
        end
        else
        begin
            after_nl_reg <= after_nl_next;
            blank_reg    <= blank_next;
            line_reg     <= line_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/tsv_queue.sv -----
// Short job queue between the front end and the output sequencer.
`default_nettype none

module tsv_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tsv_pkg::job_t  push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output tsv_pkg::job_t  head
);
    import tsv_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    job_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]    count_reg, count_next;

    assign full       = (count_reg == (PTR_W + 1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/tsv_back.sv -----
// Back end: expands each job into output bytes, one per cycle unless the output stalls, through an output register.
`default_nettype none

module tsv_back #(
    parameter int NUMBER_WIDTH = tsv_pkg::NUMBER_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  tsv_pkg::job_t  head,
    output logic           pop,
    tsv_render_if.source   rendered
);
    import tsv_pkg::*;

    localparam int CNT_W = $clog2((NUMBER_WIDTH > COUNT_DIGITS) ? NUMBER_WIDTH : COUNT_DIGITS);

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;

    phase_t           phase;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] pad_last;
    logic [CNT_W-1:0] top_digit;
    logic             has_pad;
    logic             emit;
    logic             last;
    logic [7:0]       cur_byte;

    assign has_pad   = (NUMBER_WIDTH > int'(head.ndig));
    assign pad_last  = CNT_W'(NUMBER_WIDTH - int'(head.ndig) - 1);
    assign top_digit = CNT_W'(head.ndig - DIG_CNT_W'(1));
    assign emit      = head_valid && (!out_valid_reg || rendered.ready);
    assign pop       = emit && last;

    always_comb
    begin
        // Between jobs the position comes straight from the queue head.
        if (busy_reg)
        begin
            phase = phase_reg;
            cnt   = cnt_reg;
        end
        else if (!head.numbered)
        begin
            phase = PH_BODY;
            cnt   = '0;
        end
        else if (has_pad)
        begin
            phase = PH_PAD;
            cnt   = '0;
        end
        else
        begin
            phase = PH_DIGIT;
            cnt   = top_digit;
        end

        last       = 1'b0;
        cur_byte   = CH_SPACE;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;

        case (phase)
            PH_PAD:
            begin
                cur_byte = CH_SPACE;
                if (cnt == pad_last)
                begin
                    phase_next = PH_DIGIT;
                    cnt_next   = top_digit;
                end
                else
                begin
                    phase_next = PH_PAD;
                    cnt_next   = cnt + 1'b1;
                end
            end
            PH_DIGIT:
            begin
                cur_byte = {CH_DIGIT_HI, head.digits[cnt[DIG_IDX_W-1:0]]};
                if (cnt == '0)
                begin
                    phase_next = PH_TAB;
                end
                else
                begin
                    phase_next = PH_DIGIT;
                    cnt_next   = cnt - 1'b1;
                end
            end
            PH_TAB:
            begin
                cur_byte   = CH_TAB;
                phase_next = PH_BODY;
                cnt_next   = '0;
            end
            PH_BODY:
            begin
                cur_byte   = head.body[cnt[BODY_IDX_W-1:0]];
                last       = (cnt[BODY_IDX_W-1:0] == head.body_last);
                phase_next = PH_BODY;
                cnt_next   = cnt + 1'b1;
            end
            default:
            begin
                cur_byte = CH_SPACE;
            end
        endcase

        if (emit)
        begin
            busy_next = !last;
        end
        else
        begin
            phase_next = phase_reg;
            cnt_next   = cnt_reg;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rendered.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign rendered.valid       = out_valid_reg;
    assign rendered.out_byte    = out_byte_reg;
    assign rendered.last_of_run = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_BODY;
            cnt_reg       <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/text_stream_visualizer_top.sv -----
// Top level of the text stream visualiser: configuration registers, front end, queue, back end.
//
// Each input byte produces between zero and the larger of NUMBER_WIDTH and six, plus five,
// output bytes, one per clock cycle on the output channel while it is ready, the final one
// flagged with last_of_run. Plain text, each byte expanding to a single output byte, streams
// through at one byte per cycle while the output is ready; a byte that expands to more output
// bytes holds the output sequencer until its last one is sent. Its job stays at the head of
// the two-entry job queue while it is expanded, so the queue takes one further byte before the
// input is held off. A repeated empty line dropped in squeeze mode produces no output and takes
// no sequencer time. Line numbers are kept in decimal and stop at 999999. Configuration words
// are taken at any time but should only be written while no byte is in flight.
`default_nettype none

module text_stream_visualizer_top #(
    parameter int NUMBER_WIDTH = tsv_pkg::NUMBER_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    tsv_byte_if.sink      text,
    tsv_render_if.source  rendered,
    tsv_cfg_if.sink       cfg
);
    import tsv_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic push;
    job_t push_job;
    logic full;
    logic pop;
    logic head_valid;
    job_t head;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_NUMBER_MODE:      cfg_next.number_mode      = cfg.data;
                REG_SQUEEZE_BLANK:    cfg_next.squeeze_blank    = cfg.data[0];
                REG_SHOW_ENDS:        cfg_next.show_ends        = cfg.data[0];
                REG_SHOW_TABS:        cfg_next.show_tabs        = cfg.data[0];
                REG_SHOW_NONPRINTING: cfg_next.show_nonprinting = cfg.data[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tsv_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .text     (text),
        .cfg      (cfg_reg),
        .full     (full),
        .push     (push),
        .push_job (push_job)
    );

    tsv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    tsv_back #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .rendered   (rendered)
    );

endmodule

`default_nettype wire

// ----- tb/tb_text_stream_visualizer_top.sv -----
// Self-checking testbench for the text stream visualiser: directed and random byte streams.
`timescale 1ns / 100ps

module tb_text_stream_visualizer_top;
    import tsv_pkg::*;

    localparam int          NUM_COLUMNS   = NUMBER_WIDTH_DEF;
    localparam logic [19:0] COUNT_MAX     = 20'd999999;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          STALL_LIMIT   = 2000;
    localparam int          PHASE_ITEMS   = 55;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } render_word_t;

    logic clk;
    logic rst_n;

    tsv_byte_if   text_ch ();
    tsv_render_if render_ch ();
    tsv_cfg_if    cfg_ch ();

    text_stream_visualizer_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .text     (text_ch),
        .rendered (render_ch),
        .cfg      (cfg_ch)
    );

    // Shadow copy of the block: configuration, line state and the rendered words still owed.
    cfg_t         shadow_cfg;
    logic         at_line_start;
    logic         blank_seen;
    logic [19:0]  line_number;
    render_word_t expected_render[$];

    int mismatch_count;
    int bytes_sent;
    int idle_cycles;
    int rx_hold_cycles;
    bit tx_steady;
    bit rx_steady;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] pick_text_char();
        int         roll;
        logic [7:0] ch;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            ch = 8'($urandom_range(32, 126));
        else if (roll < 75)
            ch = CH_TAB;
        else if (roll < 85)
            ch = 8'($urandom_range(0, 31));
        else if (roll < 97)
            ch = 8'($urandom_range(128, 255));
        else
            ch = CH_DEL;
        return ch;
    endfunction

    // Works out the rendered words for one accepted input byte and queues them.
    task automatic render_byte(input logic [7:0] c);
        logic [7:0]  run[$];
        logic [3:0]  digs[0:9];
        logic [19:0] v;
        logic [7:0]  low;
        logic        numbered;
        int          ndig;
        int          i;
        render_word_t word;

        if (at_line_start)
        begin
            if (shadow_cfg.squeeze_blank && c == CH_NL)
            begin
                // A second empty line in a row vanishes without touching any state.
                if (blank_seen)
                    return;
                blank_seen = 1'b1;
            end
            else
            begin
                blank_seen = 1'b0;
            end
            if (shadow_cfg.number_mode[1])
                numbered = (c != CH_NL);
            else
                numbered = shadow_cfg.number_mode[0];
            if (numbered)
            begin
                v = line_number;
                ndig = 0;
                do
                begin
                    digs[ndig] = 4'(v % 20'd10);
                    v = v / 20'd10;
                    ndig++;
                end
                while (v != 0);
                for (i = ndig; i < NUM_COLUMNS; i++)
                    run.push_back(CH_SPACE);
                for (i = ndig - 1; i >= 0; i--)
                    run.push_back({CH_DIGIT_HI, digs[i]});
                run.push_back(CH_TAB);
                if (line_number < COUNT_MAX)
                    line_number = line_number + 20'd1;
            end
        end

        if (c == CH_NL)
        begin
            if (shadow_cfg.show_ends)
                run.push_back(CH_DOLLAR);
            run.push_back(CH_NL);
        end
        else if (c == CH_TAB)
        begin
            if (shadow_cfg.show_tabs)
            begin
                run.push_back(CH_CARET);
                run.push_back(CH_I);
            end
            else
            begin
                run.push_back(CH_TAB);
            end
        end
        else if (shadow_cfg.show_nonprinting)
        begin
            if (c[7])
            begin
                run.push_back(CH_M);
                run.push_back(CH_DASH);
            end
            low = {1'b0, c[6:0]};
            if (low == CH_DEL)
            begin
                run.push_back(CH_CARET);
                run.push_back(CH_QMARK);
            end
            else if (low < CH_SPACE)
            begin
                run.push_back(CH_CARET);
                run.push_back(low + 8'd64);
            end
            else
            begin
                run.push_back(low);
            end
        end
        else
        begin
            run.push_back(c);
        end

        for (i = 0; i < run.size(); i++)
        begin
            word.out_byte    = run[i];
            word.last_of_run = (i == run.size() - 1);
            expected_render.push_back(word);
        end
        at_line_start = (c == CH_NL);
    endtask

    // Offers one byte and returns at the clock edge that takes it; valid is left high.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_steady ? 0 : (($urandom_range(0, 9) < 7) ? 0 : pick_gap());
        if (gap > 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid   <= 1'b1;
        text_ch.in_byte <= b;
        @(negedge clk);
        while (!text_ch.ready)
            @(negedge clk);
        render_byte(b);
        bytes_sent++;
        @(posedge clk);
    endtask

    // Stops offering bytes and waits until every rendered word has arrived and the block is quiet.
    task automatic wait_drain();
        text_ch.valid <= 1'b0;
        @(negedge clk);
        while (expected_render.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(negedge clk);
        while (!cfg_ch.ready)
            @(negedge clk);
        case (idx)
            REG_NUMBER_MODE:      shadow_cfg.number_mode      = val;
            REG_SQUEEZE_BLANK:    shadow_cfg.squeeze_blank    = val[0];
            REG_SHOW_ENDS:        shadow_cfg.show_ends        = val[0];
            REG_SHOW_TABS:        shadow_cfg.show_tabs        = val[0];
            REG_SHOW_NONPRINTING: shadow_cfg.show_nonprinting = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_config(input logic [1:0] number_mode, input logic squeeze,
                                input logic ends, input logic tabs, input logic nonprinting);
        wait_drain();
        write_reg(REG_NUMBER_MODE, number_mode);
        write_reg(REG_SQUEEZE_BLANK, {1'b0, squeeze});
        write_reg(REG_SHOW_ENDS, {1'b0, ends});
        write_reg(REG_SHOW_TABS, {1'b0, tabs});
        write_reg(REG_SHOW_NONPRINTING, {1'b0, nonprinting});
        cfg_ch.valid <= 1'b0;
    endtask

    // One line of text, or a run of empty lines so that squeezing has something to do.
    task automatic send_line();
        int len;
        int i;
        if ($urandom_range(0, 4) == 0)
        begin
            len = $urandom_range(1, 4);
            for (i = 0; i < len; i++)
                send_byte(CH_NL);
        end
        else
        begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
            for (i = 0; i < len; i++)
                send_byte(pick_text_char());
            send_byte(CH_NL);
        end
    endtask

    task automatic test_plain_bytes();
        apply_config(2'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h41);
        send_byte(CH_TAB);
        send_byte(CH_NL);
    endtask

    task automatic test_show_modes();
        apply_config(2'd0, 1'b0, 1'b1, 1'b1, 1'b1);
        send_byte(CH_TAB);
        send_byte(8'h00);
        send_byte(8'h1F);
        send_byte(CH_DEL);
        send_byte(8'h80);
        send_byte(8'h89);
        send_byte(8'h8A);
        send_byte(8'hFF);
        send_byte(CH_NL);
    endtask

    task automatic test_numbering();
        // Mode three behaves as non-blank numbering; squeeze keeps only the first empty line.
        apply_config(2'd3, 1'b1, 1'b0, 1'b0, 1'b0);
        send_byte(CH_NL);
        send_byte(CH_NL);
        send_byte(CH_NL);
        send_byte(8'h61);
        send_byte(CH_NL);
        apply_config(2'd1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_byte(CH_NL);
        send_byte(8'h62);
        apply_config(2'd2, 1'b0, 1'b1, 1'b0, 1'b0);
        send_byte(CH_NL);
        send_byte(CH_NL);
        send_byte(8'h63);
        send_byte(CH_NL);
    endtask

    task automatic test_backpressure();
        int i;
        apply_config(2'd1, 1'b0, 1'b1, 1'b1, 1'b1);
        rx_hold_cycles = 300;
        for (i = 0; i < 24; i++)
            send_byte(($urandom_range(0, 2) == 0) ? pick_text_char() : CH_NL);
        // Hold the stream until everything owed has come out, then carry on.
        wait_drain();
        for (i = 0; i < 8; i++)
            send_byte(pick_text_char());
    endtask

    task automatic run_text_phase();
        int start;
        int i;
        int burst;
        start = bytes_sent;
        while (bytes_sent - start < PHASE_ITEMS)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                send_line();
            end
            else
            begin
                burst = $urandom_range(1, 5);
                for (i = 0; i < burst; i++)
                    send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_random_text();
        int phase;
        apply_config(2'd3, 1'b1, 1'b1, 1'b1, 1'b1);
        run_text_phase();
        apply_config(2'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        run_text_phase();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        apply_config(2'd1, 1'b1, 1'b0, 1'b1, 1'b0);
        run_text_phase();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        for (phase = 0; phase < 4; phase++)
        begin
            apply_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            run_text_phase();
        end
    endtask

    // Receiving side: random stalls, plus a long hold-off when one is requested.
    initial
    begin : result_sink
        int stall;
        stall = 0;
        render_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles != 0)
            begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else if (stall == 0 && !rx_steady && $urandom_range(0, 99) < 25)
            begin
                stall = pick_gap();
            end
            if (stall > 0)
            begin
                render_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                render_ch.ready <= 1'b1;
            end
        end
    end

    // A word moves at the next rising edge when valid and ready are both high at the falling edge.
    always @(negedge clk)
    begin : check_word
        render_word_t want;
        if (rst_n && render_ch.valid && render_ch.ready)
        begin
            if (expected_render.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected word, got out_byte %h last_of_run %b",
                         $time, render_ch.out_byte, render_ch.last_of_run);
            end
            else
            begin
                want = expected_render.pop_front();
                if (render_ch.out_byte !== want.out_byte)
                begin
                    mismatch_count++;
                    $display("%0t: out_byte expected %h got %h",
                             $time, want.out_byte, render_ch.out_byte);
                end
                if (render_ch.last_of_run !== want.last_of_run)
                begin
                    mismatch_count++;
                    $display("%0t: last_of_run expected %b got %b",
                             $time, want.last_of_run, render_ch.last_of_run);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if ((text_ch.valid && text_ch.ready) || (render_ch.valid && render_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin : main_sequence
        mismatch_count  = 0;
        bytes_sent      = 0;
        idle_cycles     = 0;
        rx_hold_cycles  = 0;
        tx_steady       = 1'b0;
        rx_steady       = 1'b0;
        shadow_cfg      = '0;
        at_line_start   = 1'b1;
        blank_seen      = 1'b0;
        line_number     = 20'd1;
        rst_n           <= 1'b0;
        text_ch.valid   <= 1'b0;
        text_ch.in_byte <= 8'h00;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= REG_NUMBER_MODE;
        cfg_ch.data     <= 2'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_bytes();
        test_show_modes();
        test_numbering();
        test_backpressure();
        test_random_text();
        wait_drain();

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
